### hdl/ftsp_pkg.sv
// ============================================================================
// FLV tag stream parser package
// Shared types, codes and constants of the FLV tag stream parser.
// ============================================================================
package ftsp_pkg;

    localparam logic [7:0]  TYPE_AUDIO        = 8'h08;
    localparam logic [7:0]  TYPE_VIDEO        = 8'h09;
    localparam logic [7:0]  TYPE_SCRIPT       = 8'h12;
    localparam logic [7:0]  AUDIO_FORMAT_BYTE = 8'hAF;
    localparam logic [3:0]  VIDEO_CODEC_AVC   = 4'h7;
    localparam logic [7:0]  AAC_PACKET_MAX    = 8'd1;
    localparam logic [7:0]  AVC_PACKET_MAX    = 8'd2;
    localparam logic [23:0] AUDIO_SUB_LEN     = 24'd2;
    localparam logic [23:0] VIDEO_SUB_LEN     = 24'd5;

    typedef enum logic [1:0] {
        KIND_DESC    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLASS_AUDIO   = 2'd0,
        CLASS_VIDEO   = 2'd1,
        CLASS_SCRIPT  = 2'd2,
        CLASS_UNKNOWN = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_AUDIO_FORMAT = 3'd1,
        ERR_AAC_PACKET   = 3'd2,
        ERR_VIDEO_CODEC  = 3'd3,
        ERR_AVC_PACKET   = 3'd4,
        ERR_TRUNCATED    = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } byte_t;

    typedef struct packed {
        kind_t       out_kind;
        class_t      tag_class;
        logic [23:0] declared_length;
        logic [31:0] time_stamp;
        logic [23:0] stream_number;
        logic [3:0]  media_code;
        logic [1:0]  packet_kind;
        logic [23:0] composition_offset;
        logic [7:0]  payload_value;
        err_t        error_code;
        logic        last_of_tag;
    } result_t;

    typedef struct packed {
        logic load;
        logic trunc_follow;
    } res_ctl_t;

    function automatic class_t class_of(input logic [7:0] type_byte);
        class_t cls;
        case (type_byte)
            TYPE_AUDIO:  cls = CLASS_AUDIO;
            TYPE_VIDEO:  cls = CLASS_VIDEO;
            TYPE_SCRIPT: cls = CLASS_SCRIPT;
            default:     cls = CLASS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

### hdl/ftsp_in_if.sv
// ============================================================================
// FLV tag stream parser byte channel
// Valid/ready channel that carries one buffer byte and its end flag.
// ============================================================================
interface ftsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

### hdl/ftsp_out_if.sv
// ============================================================================
// FLV tag stream parser result channel
// Valid/ready channel that carries one parser result word.
// ============================================================================
interface ftsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [1:0]  tag_class;
    logic [23:0] declared_length;
    logic [31:0] time_stamp;
    logic [23:0] stream_number;
    logic [3:0]  media_code;
    logic [1:0]  packet_kind;
    logic [23:0] composition_offset;
    logic [7:0]  payload_value;
    logic [2:0]  error_code;
    logic        last_of_tag;

    modport source (
        output valid, output out_kind, output tag_class, output declared_length,
        output time_stamp, output stream_number, output media_code,
        output packet_kind, output composition_offset, output payload_value,
        output error_code, output last_of_tag, input ready
    );
    modport sink (
        input valid, input out_kind, input tag_class, input declared_length,
        input time_stamp, input stream_number, input media_code,
        input packet_kind, input composition_offset, input payload_value,
        input error_code, input last_of_tag, output ready
    );
endinterface

### hdl/flv_tag_stream_parser_top.sv
// ============================================================================
// FLV tag stream parser
// Parses FLV tag buffers byte by byte into descriptors, payload bytes and
// error words.
// ============================================================================
// The byte_stream channel takes one buffer byte per word, with buffer_end
// high on the last byte of a tag buffer. The result_stream channel gives one
// word per result: a tag descriptor once the header and any audio or video
// sub-header are parsed, then one word per payload byte, or an error word.
// Header and padding bytes produce no word.
// A byte is accepted into an input register and parsed from there; its
// result word is then loaded into the result register and valid from it.
// The parser takes one byte per cycle while no byte with a result waits on
// a full result register. A byte that ends a buffer early after a
// descriptor or a payload byte yields two words, the second a truncation
// error; the result register sends them in turn, and a following byte that
// yields a word waits for the error word to be taken.
// Reset clears the header state and the valid flags of the input and result
// registers. When the receiver stalls, the result word holds; bytes that give
// no result still pass, and byte_stream.ready drops once a byte with a result
// waits behind the full result register.
module flv_tag_stream_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    ftsp_in_if.sink    byte_stream,
    ftsp_out_if.source result_stream
);

    logic               consume;
    logic               byte_valid;
    ftsp_pkg::byte_t    byte_word;
    logic               out_free;
    ftsp_pkg::result_t  res;
    ftsp_pkg::res_ctl_t ctl;

    ftsp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .consume     (consume),
        .byte_valid  (byte_valid),
        .byte_word   (byte_word)
    );

    ftsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_word  (byte_word),
        .out_free   (out_free),
        .consume    (consume),
        .res        (res),
        .ctl        (ctl)
    );

    ftsp_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .ctl           (ctl),
        .out_free      (out_free),
        .result_stream (result_stream)
    );

endmodule

### hdl/ftsp_in_stage.sv
// ============================================================================
// FLV tag stream parser input stage
// Registers one incoming byte until the parser core takes it.
// ============================================================================
module ftsp_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    ftsp_in_if.sink          byte_stream,
    input  logic             consume,
    output logic             byte_valid,
    output ftsp_pkg::byte_t  byte_word
);

    logic            valid_reg;
    logic            valid_next;
    ftsp_pkg::byte_t word_reg;

    assign byte_stream.ready = !valid_reg || consume;
    assign byte_valid        = valid_reg;
    assign byte_word         = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_stream.valid && byte_stream.ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            word_reg.data_byte  <= byte_stream.data_byte;
            word_reg.buffer_end <= byte_stream.buffer_end;
        end
    end

endmodule

### hdl/ftsp_core.sv
// ============================================================================
// FLV tag stream parser core
// Holds the tag header state and turns one byte into at most one result,
// with a flag for a truncation error that must follow it.
// ============================================================================
module ftsp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  ftsp_pkg::byte_t   byte_word,
    input  logic              out_free,
    output logic              consume,
    output ftsp_pkg::result_t res,
    output ftsp_pkg::res_ctl_t ctl
);

    localparam logic [3:0] POS_TYPE        = 4'd0;
    localparam logic [3:0] POS_SIZE_FIRST  = 4'd1;
    localparam logic [3:0] POS_SIZE_LAST   = 4'd3;
    localparam logic [3:0] POS_STAMP_FIRST = 4'd4;
    localparam logic [3:0] POS_STAMP_LAST  = 4'd6;
    localparam logic [3:0] POS_STAMP_EXT   = 4'd7;
    localparam logic [3:0] POS_STREAM_FIRST = 4'd8;
    localparam logic [3:0] POS_STREAM_LAST = 4'd10;
    localparam logic [3:0] POS_MEDIA       = 4'd11;
    localparam logic [3:0] POS_PACKET      = 4'd12;
    localparam logic [3:0] POS_COMP_FIRST  = 4'd13;
    localparam logic [3:0] POS_COMP_LAST   = 4'd15;

    logic [3:0]  pos_reg,         pos_next;
    logic [7:0]  type_reg,        type_next;
    logic [23:0] size_reg,        size_next;
    logic [31:0] stamp_reg,       stamp_next;
    logic [23:0] stream_reg,      stream_next;
    logic [3:0]  media_reg,       media_next;
    logic [1:0]  packet_reg,      packet_next;
    logic [23:0] comp_reg,        comp_next;
    logic [23:0] remaining_reg,   remaining_next;
    logic        discard_reg,     discard_next;

    ftsp_pkg::class_t cls;
    ftsp_pkg::kind_t  res_kind;
    ftsp_pkg::err_t   res_err;
    logic             res_emit;
    logic [7:0]       res_pay;
    logic             res_last;
    logic             trunc_follow;
    logic             body_start;
    logic [23:0]      body_len;
    logic [7:0]       b;
    logic             end_flag;

    assign b        = byte_word.data_byte;
    assign end_flag = byte_word.buffer_end;
    assign cls      = ftsp_pkg::class_of(type_reg);

    always_comb
    begin
        pos_next       = pos_reg;
        type_next      = type_reg;
        size_next      = size_reg;
        stamp_next     = stamp_reg;
        stream_next    = stream_reg;
        media_next     = media_reg;
        packet_next    = packet_reg;
        comp_next      = comp_reg;
        remaining_next = remaining_reg;
        discard_next   = discard_reg;
        res_emit       = 1'b0;
        res_kind       = ftsp_pkg::KIND_DESC;
        res_err        = ftsp_pkg::ERR_NONE;
        res_pay        = 8'd0;
        res_last       = 1'b0;
        trunc_follow   = 1'b0;
        body_start     = 1'b0;
        body_len       = 24'd0;

        if (discard_reg)
        begin
            if (remaining_reg != 24'd0)
            begin
                remaining_next = remaining_reg - 24'd1;
                res_emit       = 1'b1;
                res_kind       = ftsp_pkg::KIND_PAYLOAD;
                res_pay        = b;
                res_last       = (remaining_next == 24'd0);
                trunc_follow   = end_flag && (remaining_next != 24'd0);
            end
        end
        else
        begin
            case (pos_reg) inside
                POS_TYPE:
                begin
                    type_next = b;
                end
                [POS_SIZE_FIRST:POS_SIZE_LAST]:
                begin
                    size_next = {size_reg[15:0], b};
                end
                [POS_STAMP_FIRST:POS_STAMP_LAST]:
                begin
                    stamp_next = {stamp_reg[31:24], stamp_reg[15:0], b};
                end
                POS_STAMP_EXT:
                begin
                    stamp_next = {b, stamp_reg[23:0]};
                end
                [POS_STREAM_FIRST:POS_STREAM_LAST]:
                begin
                    stream_next = {stream_reg[15:0], b};
                end
                default:
                begin
                    if (cls == ftsp_pkg::CLASS_AUDIO && pos_reg == POS_MEDIA)
                    begin
                        media_next = b[7:4];
                        if (b != ftsp_pkg::AUDIO_FORMAT_BYTE)
                        begin
                            res_emit = 1'b1;
                            res_kind = ftsp_pkg::KIND_ERROR;
                            res_err  = ftsp_pkg::ERR_AUDIO_FORMAT;
                        end
                    end
                    else if (cls == ftsp_pkg::CLASS_AUDIO && pos_reg == POS_PACKET)
                    begin
                        packet_next = b[1:0];
                        if (b > ftsp_pkg::AAC_PACKET_MAX)
                        begin
                            res_emit = 1'b1;
                            res_kind = ftsp_pkg::KIND_ERROR;
                            res_err  = ftsp_pkg::ERR_AAC_PACKET;
                        end
                        else
                        begin
                            body_start = 1'b1;
                            body_len   = (size_reg > ftsp_pkg::AUDIO_SUB_LEN) ?
                                         size_reg - ftsp_pkg::AUDIO_SUB_LEN : 24'd0;
                        end
                    end
                    else if (cls == ftsp_pkg::CLASS_VIDEO && pos_reg == POS_MEDIA)
                    begin
                        media_next = b[7:4];
                        if (b[3:0] != ftsp_pkg::VIDEO_CODEC_AVC)
                        begin
                            res_emit = 1'b1;
                            res_kind = ftsp_pkg::KIND_ERROR;
                            res_err  = ftsp_pkg::ERR_VIDEO_CODEC;
                        end
                    end
                    else if (cls == ftsp_pkg::CLASS_VIDEO && pos_reg == POS_PACKET)
                    begin
                        packet_next = b[1:0];
                        if (b > ftsp_pkg::AVC_PACKET_MAX)
                        begin
                            res_emit = 1'b1;
                            res_kind = ftsp_pkg::KIND_ERROR;
                            res_err  = ftsp_pkg::ERR_AVC_PACKET;
                        end
                    end
                    else if (cls == ftsp_pkg::CLASS_VIDEO && pos_reg >= POS_COMP_FIRST)
                    begin
                        comp_next = {comp_reg[15:0], b};
                        if (pos_reg == POS_COMP_LAST)
                        begin
                            body_start = 1'b1;
                            body_len   = (size_reg > ftsp_pkg::VIDEO_SUB_LEN) ?
                                         size_reg - ftsp_pkg::VIDEO_SUB_LEN : 24'd0;
                        end
                    end
                    else
                    begin
                        discard_next   = 1'b1;
                        remaining_next = 24'd0;
                    end
                end
            endcase

            if (res_emit)
            begin
                res_last       = 1'b1;
                discard_next   = 1'b1;
                remaining_next = 24'd0;
            end

            if (pos_reg == POS_STREAM_LAST)
            begin
                if (cls == ftsp_pkg::CLASS_SCRIPT)
                begin
                    body_start = 1'b1;
                    body_len   = size_reg;
                end
                else if (cls == ftsp_pkg::CLASS_UNKNOWN)
                begin
                    body_start = 1'b1;
                    body_len   = 24'd0;
                end
            end

            if (body_start)
            begin
                res_emit       = 1'b1;
                res_kind       = ftsp_pkg::KIND_DESC;
                res_last       = (body_len == 24'd0);
                discard_next   = 1'b1;
                remaining_next = body_len;
                trunc_follow   = end_flag && (body_len != 24'd0);
            end

            if (!discard_next)
            begin
                pos_next = pos_reg + 4'd1;
            end

            if (end_flag && !discard_next)
            begin
                res_emit = 1'b1;
                res_kind = ftsp_pkg::KIND_ERROR;
                res_err  = ftsp_pkg::ERR_TRUNCATED;
                res_last = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.out_kind           = res_kind;
        res.tag_class          = ftsp_pkg::class_of(type_next);
        res.declared_length    = size_next;
        res.time_stamp         = stamp_next;
        res.stream_number      = stream_next;
        res.media_code         = media_next;
        res.packet_kind        = packet_next;
        res.composition_offset = comp_next;
        res.payload_value      = res_pay;
        res.error_code         = res_err;
        res.last_of_tag        = res_last;
    end

    assign consume          = byte_valid && (!res_emit || out_free);
    assign ctl.load         = consume && res_emit;
    assign ctl.trunc_follow = trunc_follow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            type_reg      <= 8'd0;
            size_reg      <= 24'd0;
            stamp_reg     <= 32'd0;
            stream_reg    <= 24'd0;
            media_reg     <= 4'd0;
            packet_reg    <= 2'd0;
            comp_reg      <= 24'd0;
            remaining_reg <= 24'd0;
            discard_reg   <= 1'b0;
        end
        else if (consume)
        begin
            if (end_flag)
            begin
                pos_reg       <= 4'd0;
                type_reg      <= 8'd0;
                size_reg      <= 24'd0;
                stamp_reg     <= 32'd0;
                stream_reg    <= 24'd0;
                media_reg     <= 4'd0;
                packet_reg    <= 2'd0;
                comp_reg      <= 24'd0;
                remaining_reg <= 24'd0;
                discard_reg   <= 1'b0;
            end
            else
            begin
                pos_reg       <= pos_next;
                type_reg      <= type_next;
                size_reg      <= size_next;
                stamp_reg     <= stamp_next;
                stream_reg    <= stream_next;
                media_reg     <= media_next;
                packet_reg    <= packet_next;
                comp_reg      <= comp_next;
                remaining_reg <= remaining_next;
                discard_reg   <= discard_next;
            end
        end
    end

endmodule

### hdl/ftsp_out_buf.sv
// ============================================================================
// FLV tag stream parser result register
// Holds one result word and replays it as a truncation error when one
// is due to follow it.
// ============================================================================
module ftsp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  ftsp_pkg::result_t  res,
    input  ftsp_pkg::res_ctl_t ctl,
    output logic               out_free,
    ftsp_out_if.source         result_stream
);

    logic              valid_reg;
    logic              valid_next;
    logic              trunc_reg;
    logic              trunc_next;
    ftsp_pkg::result_t res_reg;
    ftsp_pkg::result_t res_next;
    logic              taken;

    assign taken    = valid_reg && result_stream.ready;
    assign out_free = !valid_reg || (result_stream.ready && !trunc_reg);

    always_comb
    begin
        valid_next = valid_reg;
        trunc_next = trunc_reg;
        res_next   = res_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
            trunc_next = ctl.trunc_follow;
            res_next   = res;
        end
        else if (taken)
        begin
            if (trunc_reg)
            begin
                trunc_next             = 1'b0;
                res_next.out_kind      = ftsp_pkg::KIND_ERROR;
                res_next.error_code    = ftsp_pkg::ERR_TRUNCATED;
                res_next.payload_value = 8'd0;
                res_next.last_of_tag   = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_stream.valid              = valid_reg;
    assign result_stream.out_kind           = res_reg.out_kind;
    assign result_stream.tag_class          = res_reg.tag_class;
    assign result_stream.declared_length    = res_reg.declared_length;
    assign result_stream.time_stamp         = res_reg.time_stamp;
    assign result_stream.stream_number      = res_reg.stream_number;
    assign result_stream.media_code         = res_reg.media_code;
    assign result_stream.packet_kind        = res_reg.packet_kind;
    assign result_stream.composition_offset = res_reg.composition_offset;
    assign result_stream.payload_value      = res_reg.payload_value;
    assign result_stream.error_code         = res_reg.error_code;
    assign result_stream.last_of_tag        = res_reg.last_of_tag;

endmodule
